@@ rtl/masked_byte_pattern_search_macros.svh @@
// Assertion helpers, clocked on clk_i and held off while rst_ni is low.
`ifndef MASKED_BYTE_PATTERN_SEARCH_MACROS_SVH
`define MASKED_BYTE_PATTERN_SEARCH_MACROS_SVH

// Condition holds at every clock edge.
`define MBPS_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Consequent holds at the same edge as the antecedent.
`define MBPS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds at the edge after the antecedent.
`define MBPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/mbps_pkg.sv @@
package mbps_pkg;

  localparam int unsigned BYTE_W          = 8;
  localparam int unsigned LEN_W           = 5;
  localparam int unsigned PAT_BYTES_LIM   = 16;
  localparam int unsigned OUT_OFF_W       = 32;
  localparam int unsigned CFG_DATA_W      = 64;
  localparam int unsigned CFG_IDX_W       = 3;
  localparam int unsigned PATTERN_MAX_DEF = 16;
  localparam int unsigned OFFSET_BITS_DEF = 32;
  localparam int unsigned S_TDATA_W       = 8;
  localparam int unsigned M_TDATA_W       = 40;

  localparam logic [PAT_BYTES_LIM-1:0] CARE_MASK_RST = '1;
  localparam logic [LEN_W-1:0]         PAT_LEN_RST   = LEN_W'(1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_LO  = 3'd0,
    REG_PATTERN_HI  = 3'd1,
    REG_CARE_MASK   = 3'd2,
    REG_PATTERN_LEN = 3'd3,
    REG_SEARCH_LAST = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [PAT_BYTES_LIM*BYTE_W-1:0] pattern;
    logic [PAT_BYTES_LIM-1:0]        care_mask;
    logic [LEN_W-1:0]                pattern_length;
    logic                            search_last;
  } cfg_t;

  typedef struct packed {
    logic                 found;
    logic [OUT_OFF_W-1:0] match_offset;
  } res_t;

endpackage

@@ rtl/mbps_cfg.sv @@
module mbps_cfg import mbps_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  we_i,
  input  logic [CFG_IDX_W-1:0]  index_i,
  input  logic [CFG_DATA_W-1:0] data_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      unique case (cfg_idx_e'(index_i))
        REG_PATTERN_LO:  cfg_d.pattern[CFG_DATA_W-1:0] = data_i;
        REG_PATTERN_HI:  cfg_d.pattern[2*CFG_DATA_W-1:CFG_DATA_W] = data_i;
        REG_CARE_MASK:   cfg_d.care_mask = data_i[PAT_BYTES_LIM-1:0];
        REG_PATTERN_LEN: cfg_d.pattern_length = data_i[LEN_W-1:0];
        REG_SEARCH_LAST: cfg_d.search_last = data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pattern        <= '0;
      cfg_q.care_mask      <= CARE_MASK_RST;
      cfg_q.pattern_length <= PAT_LEN_RST;
      cfg_q.search_last    <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/mbps_core.sv @@
module mbps_core import mbps_pkg::*; #(
  parameter int unsigned PATTERN_MAX = PATTERN_MAX_DEF,
  parameter int unsigned OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [BYTE_W-1:0] data_i,
  input  logic              last_i,
  input  cfg_t              cfg_i,
  output res_t              res_o
);

  localparam int unsigned IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int unsigned CNT_W = OFFSET_BITS + 1;

  logic [BYTE_W-1:0]      win_q [PATTERN_MAX];
  logic [BYTE_W-1:0]      win_d [PATTERN_MAX];
  logic [CNT_W-1:0]       cnt_q, cnt_inc, start;
  logic                   hit_q, hit_nx;
  logic [OFFSET_BITS-1:0] pos_q, pos_nx, start_sat;
  logic [LEN_W-1:0]       len_eff;
  logic                   match;
  logic [OFFSET_BITS+OUT_OFF_W-1:0] pos_ext;

  // newest byte at index 0
  always_comb begin
    win_d[0] = data_i;
    for (int i = 1; i < PATTERN_MAX; i++) begin
      win_d[i] = win_q[i-1];
    end
  end

  always_comb begin
    if (cfg_i.pattern_length == '0) begin
      len_eff = LEN_W'(1);
    end else if (cfg_i.pattern_length > LEN_W'(PATTERN_MAX)) begin
      len_eff = LEN_W'(PATTERN_MAX);
    end else begin
      len_eff = cfg_i.pattern_length;
    end
  end

  // pattern byte i sits len-1-i back from the newest byte
  always_comb begin
    logic [LEN_W-1:0] idx;
    match = 1'b1;
    for (int i = 0; i < PATTERN_MAX; i++) begin
      idx = len_eff - LEN_W'(1) - LEN_W'(i);
      if (LEN_W'(i) < len_eff && cfg_i.care_mask[i]) begin
        if (cfg_i.pattern[BYTE_W*i +: BYTE_W] != win_d[idx[IDX_W-1:0]]) begin
          match = 1'b0;
        end
      end
    end
  end

  assign cnt_inc   = (&cnt_q) ? cnt_q : cnt_q + CNT_W'(1);
  assign start     = cnt_inc - CNT_W'(len_eff);
  assign start_sat = start[CNT_W-1] ? '1 : start[OFFSET_BITS-1:0];

  always_comb begin
    hit_nx = hit_q;
    pos_nx = pos_q;
    if (cnt_inc >= CNT_W'(len_eff) && match && (cfg_i.search_last || !hit_q)) begin
      hit_nx = 1'b1;
      pos_nx = start_sat;
    end
  end

  assign pos_ext            = {{OUT_OFF_W{1'b0}}, pos_nx};
  assign res_o.found        = hit_nx;
  assign res_o.match_offset = hit_nx ? pos_ext[OUT_OFF_W-1:0] : '0;

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      win_q <= win_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      hit_q <= 1'b0;
      pos_q <= '0;
    end else if (step_i) begin
      if (last_i) begin
        cnt_q <= '0;
        hit_q <= 1'b0;
        pos_q <= '0;
      end else begin
        cnt_q <= cnt_inc;
        hit_q <= hit_nx;
        pos_q <= pos_nx;
      end
    end
  end

endmodule

@@ rtl/masked_byte_pattern_search.sv @@
// Masked byte pattern search. The region to scan streams in one byte per
// word on the slave side, tlast on its final byte. One byte is taken every
// cycle; the input stage stalls only when a region ends while the previous
// region's result is still waiting on the master side. Each byte goes through
// an input register, then a parallel compare of the shifted window against the
// masked pattern, and a region's result word is registered in the output
// register behind it and shown on the master side. The result carries a found
// flag and the start offset of the first match (search_last = 0) or the last
// match (search_last = 1), zero when nothing matched; offsets saturate at
// 2^OFFSET_BITS - 1 and are reported in 32 bits. Registers: 0 pattern bytes
// 0-7, 1 pattern bytes 8-15, 2 care mask, 3 pattern length (0 acts as 1, above
// PATTERN_MAX acts as PATTERN_MAX), 4 search_last; write them between regions.
module masked_byte_pattern_search import mbps_pkg::*; #(
  parameter int unsigned PATTERN_MAX = PATTERN_MAX_DEF,
  parameter int unsigned OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [S_TDATA_W-1:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic                  s_axis_tlast,   // last_byte
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [M_TDATA_W-1:0]  m_axis_tdata    // [0] found, [32:1] match_offset
);

  cfg_t              cfg;
  res_t              res;
  logic              in_valid_q;
  logic [BYTE_W-1:0] in_data_q;
  logic              in_last_q;
  logic              out_valid_q;
  res_t              out_res_q;
  logic              hold, advance, s_fire;

  mbps_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_we_i),
    .index_i (cfg_index_i),
    .data_i  (cfg_data_i),
    .cfg_o   (cfg)
  );

  mbps_core #(
    .PATTERN_MAX (PATTERN_MAX),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .data_i (in_data_q),
    .last_i (in_last_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // a region end cannot move on while the result slot is occupied and not draining
  assign hold          = in_last_q && out_valid_q && !m_axis_tready;
  assign advance       = in_valid_q && !hold;
  assign s_axis_tready = !in_valid_q || !hold;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_fire) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      in_data_q <= s_axis_tdata[BYTE_W-1:0];
      in_last_q <= s_axis_tlast;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && in_last_q) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_last_q) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(M_TDATA_W - OUT_OFF_W - 1){1'b0}},
                          out_res_q.match_offset, out_res_q.found};

endmodule

@@ rtl/mbps_checker.sv @@
`include "masked_byte_pattern_search_macros.svh"

module mbps_checker import mbps_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tready,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [M_TDATA_W-1:0] m_axis_tdata
);

  `MBPS_ASSERT_IMPL(a_no_hit_zero_offset, m_axis_tvalid && !m_axis_tdata[0], m_axis_tdata[OUT_OFF_W:1] == '0, "offset nonzero without a match")

  `MBPS_ASSERT_IMPL(a_pad_zero, m_axis_tvalid, m_axis_tdata[M_TDATA_W-1:OUT_OFF_W+1] == '0, "pad bits of result word set")

  `MBPS_ASSERT_IMPL(a_stall_cause, !s_axis_tready, m_axis_tvalid && !m_axis_tready, "input stalled without a blocked result")

  `MBPS_ASSERT_NEXT(a_result_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result word changed while stalled")

endmodule

bind masked_byte_pattern_search mbps_checker u_mbps_checker (.*);
